[hw/rtl/course_mono_voice_allocator_assert.svh]
// ----------------------------------------------------------------------------
// Course mono voice allocator assertion macros
// Shared property forms for the allocator checks, clocked on clk and
// disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef COURSE_MONO_VOICE_ALLOCATOR_ASSERT_SVH
`define COURSE_MONO_VOICE_ALLOCATOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CMVA_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CMVA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/cmva_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Course mono voice allocator package
// Sizes, codes and the command and status types shared by the allocator.
// ----------------------------------------------------------------------------
package cmva_pkg;

    localparam int NUM_VOICES  = 16;
    localparam int NUM_NOTES   = 32;
    localparam int STACK_DEPTH = 8;

    localparam int REQ_W   = 2;
    localparam int SLOT_W  = 5;
    localparam int PATH_W  = 8;
    localparam int KEY_W   = 10;
    localparam int VOICE_W = 4;
    localparam int TIME_W  = 64;
    localparam int ACT_W   = 2;
    localparam int DIDX_W  = 3;
    localparam int CNT_W   = 4;
    localparam int FREE_W  = 5;
    localparam int STK_AW  = VOICE_W + DIDX_W;

    localparam logic [KEY_W-1:0] KEY_MAX = 10'd1000;

    localparam logic [REQ_W-1:0] REQ_NOTE_ON  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_NOTE_OFF = 2'd1;
    localparam logic [REQ_W-1:0] REQ_RELEASE  = 2'd2;

    localparam logic [ACT_W-1:0] ACT_END    = 2'd0;
    localparam logic [ACT_W-1:0] ACT_START  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_NOFREE = 2'd2;

    typedef logic [2:0] emit_sel_t;
    localparam emit_sel_t EM_END        = 3'd0;
    localparam emit_sel_t EM_END_LATE   = 3'd1;
    localparam emit_sel_t EM_START_ITEM = 3'd2;
    localparam emit_sel_t EM_START_NEXT = 3'd3;
    localparam emit_sel_t EM_NOFREE     = 3'd4;

    typedef struct packed {
        logic      idle;
        logic      load_item;
        logic      do_release;
        logic      on_retrig;
        logic      on_alloc;
        logic      rec_rd;
        logic      rec_rd_nxt;
        logic      off_latch;
        logic      srch_rd;
        logic      srch_dec;
        logic      sh_init_ovf;
        logic      sh_init_rm;
        logic      sh_rd;
        logic      sh_wr;
        logic      push_wr;
        logic      cnt_dec;
        logic      tag_clear;
        logic      top_rd;
        logic      out_load;
        logic      out_last;
        emit_sel_t out_sel;
    } cmd_t;

    typedef struct packed {
        logic [REQ_W-1:0] req_type;
        logic             slot_ok;
        logic             mono_hit;
        logic             hit_held;
        logic             free_empty;
        logic             overflow;
        logic             rec_voice_ok;
        logic             k_zero;
        logic             stk_hit;
        logic             is_top;
        logic             cnt_one;
        logic             sh_done;
        logic             out_free;
    } status_t;

endpackage

[hw/rtl/cmva_req_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Key event channel
// Valid and ready handshake carrying one key event word.
// ----------------------------------------------------------------------------
interface cmva_req_if;
    logic                             valid;
    logic                             ready;
    logic [cmva_pkg::REQ_W-1:0]       req_type;
    logic [cmva_pkg::SLOT_W-1:0]      note_slot;
    logic [cmva_pkg::PATH_W-1:0]      path_id;
    logic [cmva_pkg::PATH_W-1:0]      course;
    logic [cmva_pkg::PATH_W-1:0]      key_in_course;
    logic [cmva_pkg::KEY_W-1:0]       key_number;
    logic [cmva_pkg::VOICE_W-1:0]     voice_in;
    logic [cmva_pkg::TIME_W-1:0]      event_time;

    modport source (
        output valid, req_type, note_slot, path_id, course, key_in_course,
               key_number, voice_in, event_time,
        input  ready
    );
    modport sink (
        input  valid, req_type, note_slot, path_id, course, key_in_course,
               key_number, voice_in, event_time,
        output ready
    );
endinterface

[hw/rtl/cmva_res_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Voice action channel
// Valid and ready handshake carrying one voice action word.
// ----------------------------------------------------------------------------
interface cmva_res_if;
    logic                          valid;
    logic                          ready;
    logic [cmva_pkg::ACT_W-1:0]    action;
    logic [cmva_pkg::VOICE_W-1:0]  voice_out;
    logic [cmva_pkg::SLOT_W-1:0]   played_slot;
    logic [cmva_pkg::KEY_W-1:0]    played_key;
    logic [cmva_pkg::TIME_W-1:0]   out_time;
    logic                          last;

    modport source (
        output valid, action, voice_out, played_slot, played_key, out_time, last,
        input  ready
    );
    modport sink (
        input  valid, action, voice_out, played_slot, played_key, out_time, last,
        output ready
    );
endinterface

[hw/rtl/cmva_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Allocator datapath
// Free voice queue, voice tags, note stacks, note records and output word.
// ----------------------------------------------------------------------------
module cmva_datapath (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic              cfg_wdata,
    input  cmva_pkg::cmd_t    cmd,
    output cmva_pkg::status_t st,
    cmva_req_if.sink          req,
    cmva_res_if.source        res
);

    logic                          mono_reg;
    logic [cmva_pkg::REQ_W-1:0]    it_req_reg;
    logic [cmva_pkg::SLOT_W-1:0]   it_slot_reg;
    logic [cmva_pkg::PATH_W-1:0]   it_path_reg;
    logic [cmva_pkg::PATH_W-1:0]   it_course_reg;
    logic [cmva_pkg::KEY_W-1:0]    it_key_reg;
    logic [cmva_pkg::VOICE_W-1:0]  it_vin_reg;
    logic [cmva_pkg::TIME_W-1:0]   it_time_reg;

    logic [cmva_pkg::VOICE_W-1:0]  v_reg;
    logic [cmva_pkg::CNT_W-1:0]    k_reg;
    logic [cmva_pkg::CNT_W-1:0]    cnt_reg;
    logic [cmva_pkg::CNT_W-1:0]    sh_end_reg;
    logic [cmva_pkg::SLOT_W-1:0]   nxt_reg;

    logic [cmva_pkg::VOICE_W-1:0]  fifo_reg [cmva_pkg::NUM_VOICES];
    logic [cmva_pkg::FREE_W-1:0]   free_cnt_reg;
    logic [cmva_pkg::NUM_VOICES-1:0] busy_reg;
    logic [cmva_pkg::NUM_VOICES-1:0] tval_reg;
    logic [cmva_pkg::PATH_W-1:0]   tpath_reg [cmva_pkg::NUM_VOICES];
    logic [cmva_pkg::PATH_W-1:0]   tcourse_reg [cmva_pkg::NUM_VOICES];
    logic [cmva_pkg::CNT_W-1:0]    scnt_reg [cmva_pkg::NUM_VOICES];

    logic [cmva_pkg::SLOT_W-1:0]   stk_mem [cmva_pkg::NUM_VOICES*cmva_pkg::STACK_DEPTH];
    logic [cmva_pkg::SLOT_W-1:0]   stk_rdata_reg;
    logic [cmva_pkg::VOICE_W+cmva_pkg::KEY_W-1:0] rec_mem [cmva_pkg::NUM_NOTES];
    logic [cmva_pkg::VOICE_W+cmva_pkg::KEY_W-1:0] rec_rdata_reg;

    logic                          out_valid_reg;
    logic [cmva_pkg::ACT_W-1:0]    out_act_reg;
    logic [cmva_pkg::VOICE_W-1:0]  out_voice_reg;
    logic [cmva_pkg::SLOT_W-1:0]   out_slot_reg;
    logic [cmva_pkg::KEY_W-1:0]    out_key_reg;
    logic [cmva_pkg::TIME_W-1:0]   out_time_reg;
    logic                          out_last_reg;

    logic                          match_any;
    logic [cmva_pkg::VOICE_W-1:0]  match_idx;
    logic [cmva_pkg::KEY_W-1:0]    key_sat;
    logic [cmva_pkg::VOICE_W-1:0]  rec_v;
    logic [cmva_pkg::KEY_W-1:0]    rec_key;
    logic [cmva_pkg::DIDX_W-1:0]   push_idx;
    logic                          ovf;
    logic                          rel_ok;
    logic                          stk_we;
    logic [cmva_pkg::STK_AW-1:0]   stk_wa;
    logic [cmva_pkg::SLOT_W-1:0]   stk_wd;
    logic                          stk_re;
    logic [cmva_pkg::STK_AW-1:0]   stk_ra;
    logic                          rec_we;
    logic                          rec_re;
    logic [cmva_pkg::SLOT_W-1:0]   rec_ra;
    logic [cmva_pkg::VOICE_W-1:0]  new_v;
    logic [cmva_pkg::CNT_W-1:0]    km1;
    logic [cmva_pkg::CNT_W-1:0]    kp1;
    logic [cmva_pkg::CNT_W-1:0]    cm2;

    assign key_sat = (req.key_number > cmva_pkg::KEY_MAX) ? cmva_pkg::KEY_MAX
                                                            : req.key_number;
    assign rec_v   = rec_rdata_reg[cmva_pkg::VOICE_W+cmva_pkg::KEY_W-1:cmva_pkg::KEY_W];
    assign rec_key = rec_rdata_reg[cmva_pkg::KEY_W-1:0];

    always_comb
    begin
        match_any = 1'b0;
        match_idx = '0;
        for (int i = cmva_pkg::NUM_VOICES - 1; i >= 0; i--)
        begin
            if (tval_reg[i] && tpath_reg[i] == it_path_reg
                && tcourse_reg[i] == it_course_reg)
            begin
                match_any = 1'b1;
                match_idx = cmva_pkg::VOICE_W'(i);
            end
        end
    end

    assign ovf      = scnt_reg[v_reg] >= cmva_pkg::CNT_W'(cmva_pkg::STACK_DEPTH);
    assign push_idx = ovf ? cmva_pkg::DIDX_W'(cmva_pkg::STACK_DEPTH - 1)
                          : scnt_reg[v_reg][cmva_pkg::DIDX_W-1:0];
    assign rel_ok   = ({1'b0, it_vin_reg} < (cmva_pkg::VOICE_W+1)'(cmva_pkg::NUM_VOICES))
                      && busy_reg[it_vin_reg] && scnt_reg[it_vin_reg] == '0
                      && free_cnt_reg < cmva_pkg::FREE_W'(cmva_pkg::NUM_VOICES);
    assign new_v    = cmd.on_retrig ? match_idx : fifo_reg[0];
    assign km1      = k_reg - cmva_pkg::CNT_W'(1);
    assign kp1      = k_reg + cmva_pkg::CNT_W'(1);
    assign cm2      = cnt_reg - cmva_pkg::CNT_W'(2);

    always_comb
    begin
        stk_we = cmd.push_wr || cmd.sh_wr;
        stk_wa = {v_reg, cmd.push_wr ? push_idx : k_reg[cmva_pkg::DIDX_W-1:0]};
        stk_wd = cmd.push_wr ? it_slot_reg : stk_rdata_reg;
        stk_re = cmd.srch_rd || cmd.sh_rd || cmd.top_rd;
        priority if (cmd.srch_rd)
            stk_ra = {v_reg, km1[cmva_pkg::DIDX_W-1:0]};
        else if (cmd.sh_rd)
            stk_ra = {v_reg, kp1[cmva_pkg::DIDX_W-1:0]};
        else
            stk_ra = {v_reg, cm2[cmva_pkg::DIDX_W-1:0]};
        rec_we = cmd.on_retrig || cmd.on_alloc;
        rec_re = cmd.rec_rd || cmd.rec_rd_nxt;
        rec_ra = cmd.rec_rd_nxt ? stk_rdata_reg : it_slot_reg;
    end

    always_ff @(posedge clk)
    begin
        if (stk_we)
            stk_mem[stk_wa] <= stk_wd;
        if (stk_re)
            stk_rdata_reg <= stk_mem[stk_ra];
        if (rec_we)
            rec_mem[it_slot_reg] <= {new_v, it_key_reg};
        if (rec_re)
            rec_rdata_reg <= rec_mem[rec_ra];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            it_req_reg    <= req.req_type;
            it_slot_reg   <= req.note_slot;
            it_path_reg   <= req.path_id;
            it_course_reg <= req.course;
            it_key_reg    <= key_sat;
            it_vin_reg    <= req.voice_in;
            it_time_reg   <= req.event_time;
        end
        if (cmd.on_retrig || cmd.on_alloc)
            v_reg <= new_v;
        if (cmd.off_latch)
        begin
            v_reg   <= rec_v;
            k_reg   <= scnt_reg[rec_v];
            cnt_reg <= scnt_reg[rec_v];
        end
        if (cmd.srch_dec)
            k_reg <= km1;
        if (cmd.sh_init_ovf)
        begin
            k_reg      <= '0;
            sh_end_reg <= cmva_pkg::CNT_W'(cmva_pkg::STACK_DEPTH - 1);
        end
        if (cmd.sh_init_rm)
        begin
            k_reg      <= km1;
            sh_end_reg <= cnt_reg - cmva_pkg::CNT_W'(1);
        end
        if (cmd.sh_wr)
            k_reg <= kp1;
        if (cmd.rec_rd_nxt)
            nxt_reg <= stk_rdata_reg;
        if (cmd.on_alloc)
        begin
            tpath_reg[fifo_reg[0]]   <= it_path_reg;
            tcourse_reg[fifo_reg[0]] <= it_course_reg;
        end
        if (cmd.out_load)
        begin
            out_last_reg <= cmd.out_last;
            unique case (cmd.out_sel)
                cmva_pkg::EM_END:
                begin
                    out_act_reg   <= cmva_pkg::ACT_END;
                    out_voice_reg <= v_reg;
                    out_slot_reg  <= '0;
                    out_key_reg   <= '0;
                    out_time_reg  <= it_time_reg;
                end
                cmva_pkg::EM_END_LATE:
                begin
                    out_act_reg   <= cmva_pkg::ACT_END;
                    out_voice_reg <= v_reg;
                    out_slot_reg  <= '0;
                    out_key_reg   <= '0;
                    out_time_reg  <= it_time_reg + cmva_pkg::TIME_W'(1);
                end
                cmva_pkg::EM_START_ITEM:
                begin
                    out_act_reg   <= cmva_pkg::ACT_START;
                    out_voice_reg <= v_reg;
                    out_slot_reg  <= it_slot_reg;
                    out_key_reg   <= it_key_reg;
                    out_time_reg  <= it_time_reg;
                end
                cmva_pkg::EM_START_NEXT:
                begin
                    out_act_reg   <= cmva_pkg::ACT_START;
                    out_voice_reg <= v_reg;
                    out_slot_reg  <= nxt_reg;
                    out_key_reg   <= rec_key;
                    out_time_reg  <= it_time_reg;
                end
                default:
                begin
                    out_act_reg   <= cmva_pkg::ACT_NOFREE;
                    out_voice_reg <= '0;
                    out_slot_reg  <= it_slot_reg;
                    out_key_reg   <= it_key_reg;
                    out_time_reg  <= it_time_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mono_reg      <= 1'b1;
            free_cnt_reg  <= cmva_pkg::FREE_W'(cmva_pkg::NUM_VOICES);
            busy_reg      <= '0;
            tval_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < cmva_pkg::NUM_VOICES; i++)
            begin
                fifo_reg[i] <= cmva_pkg::VOICE_W'(i);
                scnt_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
                mono_reg <= cfg_wdata;
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (res.ready)
                out_valid_reg <= 1'b0;
            if (cmd.do_release && rel_ok)
            begin
                busy_reg[it_vin_reg] <= 1'b0;
                fifo_reg[free_cnt_reg[cmva_pkg::VOICE_W-1:0]] <= it_vin_reg;
                free_cnt_reg <= free_cnt_reg + cmva_pkg::FREE_W'(1);
            end
            if (cmd.on_alloc)
            begin
                for (int i = 0; i < cmva_pkg::NUM_VOICES - 1; i++)
                    fifo_reg[i] <= fifo_reg[i+1];
                free_cnt_reg          <= free_cnt_reg - cmva_pkg::FREE_W'(1);
                busy_reg[fifo_reg[0]] <= 1'b1;
                tval_reg[fifo_reg[0]] <= mono_reg;
                scnt_reg[fifo_reg[0]] <= '0;
            end
            if (cmd.push_wr)
                scnt_reg[v_reg] <= {1'b0, push_idx} + cmva_pkg::CNT_W'(1);
            if (cmd.cnt_dec)
                scnt_reg[v_reg] <= cnt_reg - cmva_pkg::CNT_W'(1);
            if (cmd.tag_clear)
            begin
                for (int i = 0; i < cmva_pkg::NUM_VOICES; i++)
                begin
                    if (tpath_reg[i] == tpath_reg[v_reg]
                        && tcourse_reg[i] == tcourse_reg[v_reg])
                        tval_reg[i] <= 1'b0;
                end
            end
        end
    end

    always_comb
    begin
        st.req_type     = it_req_reg;
        st.slot_ok      = {1'b0, it_slot_reg} < (cmva_pkg::SLOT_W+1)'(cmva_pkg::NUM_NOTES);
        st.mono_hit     = mono_reg && match_any;
        st.hit_held     = scnt_reg[match_idx] != '0;
        st.free_empty   = free_cnt_reg == '0;
        st.overflow     = ovf;
        st.rec_voice_ok = {1'b0, rec_v} < (cmva_pkg::VOICE_W+1)'(cmva_pkg::NUM_VOICES);
        st.k_zero       = k_reg == '0;
        st.stk_hit      = stk_rdata_reg == it_slot_reg;
        st.is_top       = k_reg == cnt_reg;
        st.cnt_one      = cnt_reg == cmva_pkg::CNT_W'(1);
        st.sh_done      = k_reg == sh_end_reg;
        st.out_free     = !out_valid_reg || res.ready;
    end

    assign req.ready       = cmd.idle;
    assign res.valid       = out_valid_reg;
    assign res.action      = out_act_reg;
    assign res.voice_out   = out_voice_reg;
    assign res.played_slot = out_slot_reg;
    assign res.played_key  = out_key_reg;
    assign res.out_time    = out_time_reg;
    assign res.last        = out_last_reg;

endmodule

[hw/rtl/cmva_controller.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Allocator controller
// Sequences note on, note off and release handling over the datapath.
// ----------------------------------------------------------------------------
module cmva_controller (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    input  cmva_pkg::status_t st,
    output cmva_pkg::cmd_t    cmd
);

    localparam logic [4:0] S_IDLE        = 5'd0;
    localparam logic [4:0] S_DEC         = 5'd1;
    localparam logic [4:0] S_E_END_ON    = 5'd2;
    localparam logic [4:0] S_E_START_ON  = 5'd3;
    localparam logic [4:0] S_E_NOFREE    = 5'd4;
    localparam logic [4:0] S_PUSH        = 5'd5;
    localparam logic [4:0] S_PUSH_WR     = 5'd6;
    localparam logic [4:0] S_SH_RD       = 5'd7;
    localparam logic [4:0] S_SH_WR       = 5'd8;
    localparam logic [4:0] S_RM_DONE     = 5'd9;
    localparam logic [4:0] S_OFF_REC     = 5'd10;
    localparam logic [4:0] S_SRCH_RD     = 5'd11;
    localparam logic [4:0] S_SRCH_CHK    = 5'd12;
    localparam logic [4:0] S_TOP_WAIT    = 5'd13;
    localparam logic [4:0] S_E_END_OFF   = 5'd14;
    localparam logic [4:0] S_E_START_NXT = 5'd15;
    localparam logic [4:0] S_E_END_LATE  = 5'd16;

    logic [4:0] state_reg;
    logic [4:0] state_next;
    logic       ret_push_reg;
    logic       ret_push_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            ret_push_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            ret_push_reg <= ret_push_next;
        end
    end

    always_comb
    begin
        cmd           = '0;
        cmd.out_sel   = cmva_pkg::EM_END;
        state_next    = state_reg;
        ret_push_next = ret_push_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.idle = 1'b1;
                if (req_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = S_DEC;
                end
            end
            S_DEC:
            begin
                state_next = S_IDLE;
                if (st.req_type == cmva_pkg::REQ_RELEASE)
                    cmd.do_release = 1'b1;
                else if (st.req_type == cmva_pkg::REQ_NOTE_ON && st.slot_ok)
                begin
                    if (st.mono_hit)
                    begin
                        cmd.on_retrig = 1'b1;
                        state_next    = st.hit_held ? S_E_END_ON : S_E_START_ON;
                    end
                    else if (st.free_empty)
                        state_next = S_E_NOFREE;
                    else
                    begin
                        cmd.on_alloc = 1'b1;
                        state_next   = S_E_START_ON;
                    end
                end
                else if (st.req_type == cmva_pkg::REQ_NOTE_OFF && st.slot_ok)
                begin
                    cmd.rec_rd = 1'b1;
                    state_next = S_OFF_REC;
                end
            end
            S_E_END_ON:
            begin
                if (st.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = cmva_pkg::EM_END;
                    state_next   = S_E_START_ON;
                end
            end
            S_E_START_ON:
            begin
                if (st.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_last = 1'b1;
                    cmd.out_sel  = cmva_pkg::EM_START_ITEM;
                    state_next   = S_PUSH;
                end
            end
            S_E_NOFREE:
            begin
                if (st.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_last = 1'b1;
                    cmd.out_sel  = cmva_pkg::EM_NOFREE;
                    state_next   = S_IDLE;
                end
            end
            S_PUSH:
            begin
                if (st.overflow)
                begin
                    cmd.sh_init_ovf = 1'b1;
                    ret_push_next   = 1'b1;
                    state_next      = S_SH_RD;
                end
                else
                    state_next = S_PUSH_WR;
            end
            S_PUSH_WR:
            begin
                cmd.push_wr = 1'b1;
                state_next  = S_IDLE;
            end
            S_SH_RD:
            begin
                if (st.sh_done)
                    state_next = ret_push_reg ? S_PUSH_WR : S_RM_DONE;
                else
                begin
                    cmd.sh_rd  = 1'b1;
                    state_next = S_SH_WR;
                end
            end
            S_SH_WR:
            begin
                cmd.sh_wr  = 1'b1;
                state_next = S_SH_RD;
            end
            S_RM_DONE:
            begin
                cmd.cnt_dec = 1'b1;
                state_next  = S_IDLE;
            end
            S_OFF_REC:
            begin
                cmd.off_latch = 1'b1;
                state_next    = st.rec_voice_ok ? S_SRCH_RD : S_IDLE;
            end
            S_SRCH_RD:
            begin
                if (st.k_zero)
                    state_next = S_IDLE;
                else
                begin
                    cmd.srch_rd = 1'b1;
                    state_next  = S_SRCH_CHK;
                end
            end
            S_SRCH_CHK:
            begin
                if (!st.stk_hit)
                begin
                    cmd.srch_dec = 1'b1;
                    state_next   = S_SRCH_RD;
                end
                else if (!st.is_top)
                begin
                    cmd.sh_init_rm = 1'b1;
                    ret_push_next  = 1'b0;
                    state_next     = S_SH_RD;
                end
                else if (st.cnt_one)
                begin
                    cmd.cnt_dec   = 1'b1;
                    cmd.tag_clear = 1'b1;
                    state_next    = S_E_END_LATE;
                end
                else
                begin
                    cmd.cnt_dec = 1'b1;
                    cmd.top_rd  = 1'b1;
                    state_next  = S_TOP_WAIT;
                end
            end
            S_TOP_WAIT:
            begin
                cmd.rec_rd_nxt = 1'b1;
                state_next     = S_E_END_OFF;
            end
            S_E_END_OFF:
            begin
                if (st.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = cmva_pkg::EM_END;
                    state_next   = S_E_START_NXT;
                end
            end
            S_E_START_NXT:
            begin
                if (st.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_last = 1'b1;
                    cmd.out_sel  = cmva_pkg::EM_START_NEXT;
                    state_next   = S_IDLE;
                end
            end
            S_E_END_LATE:
            begin
                if (st.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_last = 1'b1;
                    cmd.out_sel  = cmva_pkg::EM_END_LATE;
                    state_next   = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

endmodule

[hw/rtl/course_mono_voice_allocator.sv]
`timescale 1ns / 1ps
// A release is decided in the decode state; a note on emits its actions, then
// pushes the slot, shifting out the oldest entry of a full note stack. A note off
// searches the stack from the top and shifts down the entries above a lower note.
// Words are taken only in idle, so each event ends before the next is accepted.
// Reset clears the free queue to voices in order, tags, counts and the output;
// the note stack and note record memories are not cleared.
// ----------------------------------------------------------------------------
// Course mono voice allocator
// Maps key events onto voices with, when mono is enabled, one note per path and
// course and last-note priority.
// ----------------------------------------------------------------------------
`include "course_mono_voice_allocator_assert.svh"

module course_mono_voice_allocator (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    cmva_req_if.sink    req,
    cmva_res_if.source  res
);

    cmva_pkg::cmd_t    cmd;
    cmva_pkg::status_t st;

    cmva_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .st        (st),
        .cmd       (cmd)
    );

    cmva_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .st        (st),
        .req       (req),
        .res       (res)
    );

    `CMVA_ASSERT_NEXT(a_busy_after_accept, req.valid && req.ready, !req.ready, "word taken while busy")
    `CMVA_ASSERT_IMPL(a_no_overwrite, cmd.out_load, st.out_free, "pending result overwritten")
    `CMVA_ASSERT_IMPL(a_alloc_has_voice, cmd.on_alloc, !st.free_empty, "voice taken from empty queue")

endmodule

[dv/tb_course_mono_voice_allocator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Course mono voice allocator testbench
// Drives key events into the allocator and checks every voice action against
// a predictor that keeps its own free queue, tags, note stacks and note
// records. Directed words cover retrigger, replay, stack overflow, saturation,
// time wrap and an empty free queue; random phases run with both settings
// of the mono enable and with varied back-pressure on both sides.
// ----------------------------------------------------------------------------
module tb_course_mono_voice_allocator;

    localparam logic [cmva_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;

    typedef struct {
        logic [cmva_pkg::ACT_W-1:0]   action;
        logic [cmva_pkg::VOICE_W-1:0] voice;
        logic [cmva_pkg::SLOT_W-1:0]  slot;
        logic [cmva_pkg::KEY_W-1:0]   key;
        logic [cmva_pkg::TIME_W-1:0]  stamp;
        logic                         last;
    } voice_action_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic cfg_wdata = 1'b0;

    cmva_req_if req ();
    cmva_res_if res ();

    course_mono_voice_allocator u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req),
        .res       (res)
    );

    always #5 clk = ~clk;

    // Allocator state as the predictor sees it.
    logic                         mono;
    logic [cmva_pkg::VOICE_W-1:0] free_q[$];
    logic                         busy[cmva_pkg::NUM_VOICES];
    logic                         tag_v[cmva_pkg::NUM_VOICES];
    logic [cmva_pkg::PATH_W-1:0]  tag_p[cmva_pkg::NUM_VOICES];
    logic [cmva_pkg::PATH_W-1:0]  tag_c[cmva_pkg::NUM_VOICES];
    logic [cmva_pkg::SLOT_W-1:0]  held[cmva_pkg::NUM_VOICES][cmva_pkg::STACK_DEPTH];
    int                           held_cnt[cmva_pkg::NUM_VOICES];
    logic [cmva_pkg::VOICE_W-1:0] rec_voice[cmva_pkg::NUM_NOTES];
    logic [cmva_pkg::KEY_W-1:0]   rec_key[cmva_pkg::NUM_NOTES];
    logic                         slot_seen[cmva_pkg::NUM_NOTES];

    voice_action_t expected_actions[$];

    int errors = 0;
    int words_sent = 0;
    int actions_seen = 0;
    int nofree_seen = 0;
    int snd_idle = 0;
    int rcv_idle = 0;
    int hold_cycles = 0;

    task automatic report_mismatch(input string what);
        $display("ERROR %0t: %s", $realtime, what);
        errors++;
    endtask

    task automatic push_action(input logic [cmva_pkg::ACT_W-1:0] a,
                               input logic [cmva_pkg::VOICE_W-1:0] v,
                               input logic [cmva_pkg::SLOT_W-1:0] s,
                               input logic [cmva_pkg::KEY_W-1:0] k,
                               input logic [cmva_pkg::TIME_W-1:0] t);
        voice_action_t e;
        e.action = a;
        e.voice = v;
        e.slot = s;
        e.key = k;
        e.stamp = t;
        e.last = 1'b0;
        expected_actions.push_back(e);
    endtask

    task automatic hold_slot(input int v, input logic [cmva_pkg::SLOT_W-1:0] s);
        if (held_cnt[v] >= cmva_pkg::STACK_DEPTH)
        begin
            for (int i = 0; i < cmva_pkg::STACK_DEPTH - 1; i++)
                held[v][i] = held[v][i + 1];
            held_cnt[v] = cmva_pkg::STACK_DEPTH - 1;
        end
        held[v][held_cnt[v]] = s;
        held_cnt[v]++;
    endtask

    task automatic allocate_note(input logic [cmva_pkg::SLOT_W-1:0] s,
                                 input logic [cmva_pkg::PATH_W-1:0] p,
                                 input logic [cmva_pkg::PATH_W-1:0] c,
                                 input logic [cmva_pkg::KEY_W-1:0] k,
                                 input logic [cmva_pkg::TIME_W-1:0] t);
        int v;
        if (mono)
        begin
            for (int i = 0; i < cmva_pkg::NUM_VOICES; i++)
            begin
                if (tag_v[i] && tag_p[i] == p && tag_c[i] == c)
                begin
                    if (held_cnt[i] > 0)
                        push_action(cmva_pkg::ACT_END, cmva_pkg::VOICE_W'(i), '0, '0, t);
                    push_action(cmva_pkg::ACT_START, cmva_pkg::VOICE_W'(i), s, k, t);
                    hold_slot(i, s);
                    rec_voice[s] = cmva_pkg::VOICE_W'(i);
                    rec_key[s] = k;
                    return;
                end
            end
        end
        if (free_q.size() == 0)
        begin
            push_action(cmva_pkg::ACT_NOFREE, '0, s, k, t);
            return;
        end
        v = free_q[0];
        free_q.delete(0);
        busy[v] = 1'b1;
        tag_p[v] = p;
        tag_c[v] = c;
        tag_v[v] = mono;
        held_cnt[v] = 0;
        hold_slot(v, s);
        rec_voice[s] = cmva_pkg::VOICE_W'(v);
        rec_key[s] = k;
        push_action(cmva_pkg::ACT_START, cmva_pkg::VOICE_W'(v), s, k, t);
    endtask

    task automatic lift_note(input logic [cmva_pkg::SLOT_W-1:0] s,
                             input logic [cmva_pkg::TIME_W-1:0] t);
        int v;
        int pos;
        logic [cmva_pkg::SLOT_W-1:0] nxt;
        v = rec_voice[s];
        pos = -1;
        for (int i = held_cnt[v] - 1; i >= 0; i--)
        begin
            if (held[v][i] == s)
            begin
                pos = i;
                break;
            end
        end
        if (pos < 0)
            return;
        if (pos < held_cnt[v] - 1)
        begin
            for (int i = pos; i < held_cnt[v] - 1; i++)
                held[v][i] = held[v][i + 1];
            held_cnt[v]--;
            return;
        end
        held_cnt[v]--;
        if (held_cnt[v] == 0)
        begin
            for (int i = 0; i < cmva_pkg::NUM_VOICES; i++)
                if (tag_v[i] && tag_p[i] == tag_p[v] && tag_c[i] == tag_c[v])
                    tag_v[i] = 1'b0;
            tag_v[v] = 1'b0;
            push_action(cmva_pkg::ACT_END, cmva_pkg::VOICE_W'(v), '0, '0, t + 64'd1);
            return;
        end
        nxt = held[v][held_cnt[v] - 1];
        push_action(cmva_pkg::ACT_END, cmva_pkg::VOICE_W'(v), '0, '0, t);
        push_action(cmva_pkg::ACT_START, cmva_pkg::VOICE_W'(v), nxt, rec_key[nxt], t);
    endtask

    task automatic predict_actions(input logic [cmva_pkg::REQ_W-1:0] rt,
                                   input logic [cmva_pkg::SLOT_W-1:0] s,
                                   input logic [cmva_pkg::PATH_W-1:0] p,
                                   input logic [cmva_pkg::PATH_W-1:0] c,
                                   input logic [cmva_pkg::KEY_W-1:0] k,
                                   input logic [cmva_pkg::VOICE_W-1:0] vin,
                                   input logic [cmva_pkg::TIME_W-1:0] t);
        int n_prior;
        logic [cmva_pkg::KEY_W-1:0] ks;
        n_prior = expected_actions.size();
        ks = (k > cmva_pkg::KEY_MAX) ? cmva_pkg::KEY_MAX : k;
        if (rt == cmva_pkg::REQ_NOTE_ON)
        begin
            allocate_note(s, p, c, ks, t);
        end
        else if (rt == cmva_pkg::REQ_NOTE_OFF)
        begin
            lift_note(s, t);
        end
        else if (rt == cmva_pkg::REQ_RELEASE)
        begin
            if (busy[vin] && held_cnt[vin] == 0 && free_q.size() < cmva_pkg::NUM_VOICES)
            begin
                busy[vin] = 1'b0;
                free_q.push_back(vin);
            end
        end
        if (expected_actions.size() > n_prior)
            expected_actions[$].last = 1'b1;
    endtask

    task automatic send_word(input logic [cmva_pkg::REQ_W-1:0] rt,
                             input logic [cmva_pkg::SLOT_W-1:0] s,
                             input logic [cmva_pkg::PATH_W-1:0] p,
                             input logic [cmva_pkg::PATH_W-1:0] c,
                             input logic [cmva_pkg::KEY_W-1:0] k,
                             input logic [cmva_pkg::VOICE_W-1:0] vin,
                             input logic [cmva_pkg::TIME_W-1:0] t);
        @(negedge clk);
        while ($urandom_range(99) < snd_idle)
        begin
            req.valid = 1'b0;
            @(negedge clk);
        end
        req.valid = 1'b1;
        req.req_type = rt;
        req.note_slot = s;
        req.path_id = p;
        req.course = c;
        req.key_in_course = cmva_pkg::PATH_W'($urandom);
        req.key_number = k;
        req.voice_in = vin;
        req.event_time = t;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        if (rt == cmva_pkg::REQ_NOTE_ON)
            slot_seen[s] = 1'b1;
        predict_actions(rt, s, p, c, k, vin, t);
        words_sent++;
    endtask

    task automatic wait_drained();
        @(negedge clk);
        req.valid = 1'b0;
        while (expected_actions.size() != 0)
            @(negedge clk);
        repeat (60) @(negedge clk);
    endtask

    task automatic write_mono(input logic value);
        wait_drained();
        cfg_we = 1'b1;
        cfg_wdata = value;
        @(negedge clk);
        cfg_we = 1'b0;
        mono = value;
    endtask

    task automatic random_word();
        int sel;
        int v;
        int tops[$];
        logic [cmva_pkg::REQ_W-1:0] rt;
        logic [cmva_pkg::SLOT_W-1:0] s;
        logic [cmva_pkg::PATH_W-1:0] p;
        logic [cmva_pkg::PATH_W-1:0] c;
        logic [cmva_pkg::VOICE_W-1:0] vin;
        logic [cmva_pkg::TIME_W-1:0] t;
        sel = $urandom_range(99);
        s = cmva_pkg::SLOT_W'($urandom);
        p = ($urandom_range(3) == 0) ? cmva_pkg::PATH_W'($urandom)
                                     : cmva_pkg::PATH_W'($urandom_range(2));
        c = ($urandom_range(3) == 0) ? cmva_pkg::PATH_W'($urandom)
                                     : cmva_pkg::PATH_W'($urandom_range(2));
        vin = cmva_pkg::VOICE_W'($urandom);
        t = ($urandom_range(19) == 0) ? '1 : {$urandom, $urandom};
        rt = cmva_pkg::REQ_NOTE_ON;
        if (sel >= 45 && sel < 80)
        begin
            rt = cmva_pkg::REQ_NOTE_OFF;
            for (int i = 0; i < cmva_pkg::NUM_VOICES; i++)
                if (held_cnt[i] > 0)
                    tops.push_back(held[i][held_cnt[i] - 1]);
            if (tops.size() > 0 && $urandom_range(9) < 7)
                s = cmva_pkg::SLOT_W'(tops[$urandom_range(tops.size() - 1)]);
            else if (!slot_seen[s])
                rt = cmva_pkg::REQ_NOTE_ON;
        end
        else if (sel >= 80 && sel < 96)
        begin
            rt = cmva_pkg::REQ_RELEASE;
            v = $urandom_range(cmva_pkg::NUM_VOICES - 1);
            for (int i = 0; i < cmva_pkg::NUM_VOICES; i++)
                if (busy[(v + i) % cmva_pkg::NUM_VOICES]
                        && held_cnt[(v + i) % cmva_pkg::NUM_VOICES] == 0
                        && $urandom_range(3) != 0)
                begin
                    vin = cmva_pkg::VOICE_W'((v + i) % cmva_pkg::NUM_VOICES);
                    break;
                end
        end
        else if (sel >= 96)
        begin
            rt = REQ_UNUSED;
        end
        send_word(rt, s, p, c, cmva_pkg::KEY_W'($urandom), vin, t);
    endtask

    task automatic test_directed();
        send_word(cmva_pkg::REQ_NOTE_ON, 5'd0, 8'd0, 8'd0, 10'd0, 4'd0, 64'd0);
        send_word(cmva_pkg::REQ_NOTE_ON, 5'd1, 8'd0, 8'd0, 10'd1023, 4'd0, '1);
        send_word(cmva_pkg::REQ_NOTE_OFF, 5'd0, 8'd0, 8'd0, 10'd0, 4'd0, 64'd10);
        send_word(cmva_pkg::REQ_NOTE_OFF, 5'd1, 8'd0, 8'd0, 10'd0, 4'd0, '1);
        send_word(cmva_pkg::REQ_RELEASE, 5'd0, 8'd0, 8'd0, 10'd0, 4'd0, 64'd20);
        send_word(cmva_pkg::REQ_RELEASE, 5'd0, 8'd0, 8'd0, 10'd0, 4'd0, 64'd21);
        send_word(cmva_pkg::REQ_RELEASE, 5'd0, 8'd0, 8'd0, 10'd0, 4'd15, 64'd22);
        send_word(REQ_UNUSED, 5'd31, 8'hff, 8'hff, 10'd1023, 4'd15, '1);
        send_word(cmva_pkg::REQ_NOTE_ON, 5'd31, 8'hff, 8'hff, 10'd1000, 4'd15, 64'd30);
        for (int i = 2; i <= 10; i++)
            send_word(cmva_pkg::REQ_NOTE_ON, cmva_pkg::SLOT_W'(i), 8'd7, 8'd9,
                      cmva_pkg::KEY_W'(100 + i), 4'd0, cmva_pkg::TIME_W'(40 + i));
        send_word(cmva_pkg::REQ_NOTE_OFF, 5'd10, 8'd0, 8'd0, 10'd0, 4'd0, 64'd60);
        send_word(cmva_pkg::REQ_NOTE_OFF, 5'd2, 8'd0, 8'd0, 10'd0, 4'd0, 64'd61);
        send_word(cmva_pkg::REQ_NOTE_OFF, 5'd31, 8'd0, 8'd0, 10'd0, 4'd0,
                  64'h8000_0000_0000_0000);
    endtask

    task automatic test_free_queue_empty();
        write_mono(1'b0);
        for (int i = 0; i < 18; i++)
            send_word(cmva_pkg::REQ_NOTE_ON, cmva_pkg::SLOT_W'(12 + i), 8'd1, 8'd1,
                      cmva_pkg::KEY_W'($urandom), 4'd0, cmva_pkg::TIME_W'(100 + i));
    endtask

    task automatic test_random_phase(input int count, input int sidle, input int ridle,
                                     input logic value);
        write_mono(value);
        snd_idle = sidle;
        rcv_idle = ridle;
        repeat (count)
            random_word();
    endtask

    task automatic test_backpressure();
        snd_idle = 0;
        rcv_idle = 0;
        hold_cycles = 400;
        repeat (40)
            random_word();
    endtask

    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            res.ready <= 1'b0;
        end
        else
        begin
            res.ready <= ($urandom_range(99) >= rcv_idle);
        end
    end

    always @(posedge clk)
    begin
        voice_action_t e;
        if (rst_n && res.valid && res.ready)
        begin
            actions_seen++;
            if (res.action == cmva_pkg::ACT_NOFREE)
                nofree_seen++;
            if (expected_actions.size() == 0)
            begin
                report_mismatch("voice action with no word outstanding");
            end
            else
            begin
                e = expected_actions[0];
                expected_actions.delete(0);
                if (res.action !== e.action)
                    report_mismatch($sformatf("action %0d, want %0d", res.action, e.action));
                if (res.voice_out !== e.voice)
                    report_mismatch($sformatf("voice %0d, want %0d", res.voice_out, e.voice));
                if (res.played_slot !== e.slot)
                    report_mismatch($sformatf("slot %0d, want %0d", res.played_slot, e.slot));
                if (res.played_key !== e.key)
                    report_mismatch($sformatf("key %0d, want %0d", res.played_key, e.key));
                if (res.out_time !== e.stamp)
                    report_mismatch($sformatf("time %0h, want %0h", res.out_time, e.stamp));
                if (res.last !== e.last)
                    report_mismatch($sformatf("last %0b, want %0b", res.last, e.last));
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("ERROR: timeout with %0d actions outstanding", expected_actions.size());
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        req.valid = 1'b0;
        req.req_type = '0;
        req.note_slot = '0;
        req.path_id = '0;
        req.course = '0;
        req.key_in_course = '0;
        req.key_number = '0;
        req.voice_in = '0;
        req.event_time = '0;
        mono = 1'b1;
        for (int i = 0; i < cmva_pkg::NUM_VOICES; i++)
        begin
            free_q.push_back(cmva_pkg::VOICE_W'(i));
            busy[i] = 1'b0;
            tag_v[i] = 1'b0;
            tag_p[i] = '0;
            tag_c[i] = '0;
            held_cnt[i] = 0;
        end
        for (int i = 0; i < cmva_pkg::NUM_NOTES; i++)
            slot_seen[i] = 1'b0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_free_queue_empty();
        test_random_phase(270, 28, 69, 1'b1);
        test_backpressure();
        test_random_phase(260, 69, 28, 1'b0);
        test_random_phase(260, 0, 0, 1'b1);

        wait_drained();
        $display("Sent %0d key event words and checked %0d voice action words.",
                 words_sent, actions_seen);
        $display("Both mono settings, %0d refusals for lack of a voice, %0d mismatches.",
                 nofree_seen, errors);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

[course_mono_voice_allocator.f]
+incdir+hw/rtl
hw/rtl/cmva_pkg.sv
hw/rtl/cmva_req_if.sv
hw/rtl/cmva_res_if.sv
hw/rtl/cmva_datapath.sv
hw/rtl/cmva_controller.sv
hw/rtl/course_mono_voice_allocator.sv
dv/tb_course_mono_voice_allocator.sv
